// ===== hw/rtl/blpm_pkg.sv =====
// ----------------------------------------------------------------------------
// blpm_pkg
// Shared types and constants of the binary trie prefix match block.
// ----------------------------------------------------------------------------
package blpm_pkg;

    localparam int NodeCount   = 4096;
    localparam int IdxW        = $clog2(NodeCount);
    localparam int CntW        = IdxW + 1;
    localparam int AddrBits    = 32;
    localparam int LenW        = 6;
    localparam int LabelW      = 16;
    localparam int CmdW        = 2;
    localparam int StatW       = 2;

    localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
    localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
    localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [StatW-1:0] ST_OK     = 2'd0;
    localparam logic [StatW-1:0] ST_FULL   = 2'd1;
    localparam logic [StatW-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic              marked;
        logic [LabelW-1:0] label;
        logic [IdxW-1:0]   child0;
        logic [IdxW-1:0]   child1;
        logic [IdxW-1:0]   parent;
    } t_node;

    typedef struct packed {
        logic [CmdW-1:0]     command;
        logic [AddrBits-1:0] address;
        logic [LenW-1:0]     prefix_len;
        logic [LabelW-1:0]   label;
    } t_req;

    typedef struct packed {
        logic [LabelW-1:0] result_label;
        logic [StatW-1:0]  status;
        logic [CntW-1:0]   entry_total;
    } t_rsp;

endpackage

// ===== hw/rtl/blpm_engine.sv =====
// ----------------------------------------------------------------------------
// blpm_engine
// Trie walker: node pool and free stack memories, insert/delete/lookup FSM.
// ----------------------------------------------------------------------------
module blpm_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  blpm_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output blpm_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic [blpm_pkg::LabelW-1:0]   i_cfg_label
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WALK = 4'd1;
    localparam logic [3:0] S_WLD  = 4'd2;
    localparam logic [3:0] S_CAP  = 4'd3;
    localparam logic [3:0] S_A0   = 4'd4;
    localparam logic [3:0] S_A1   = 4'd5;
    localparam logic [3:0] S_A2   = 4'd6;
    localparam logic [3:0] S_MARK = 4'd7;
    localparam logic [3:0] S_DCHK = 4'd8;
    localparam logic [3:0] S_DLD  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam int IdxW = blpm_pkg::IdxW;
    localparam int CntW = blpm_pkg::CntW;
    localparam logic [CntW-1:0] CntMax = CntW'(blpm_pkg::NodeCount);
    localparam logic [blpm_pkg::LenW-1:0] LenOne = blpm_pkg::LenW'(1);

    // memories
    blpm_pkg::t_node node_mem [blpm_pkg::NodeCount];
    logic [IdxW-1:0] free_mem [blpm_pkg::NodeCount];
    blpm_pkg::t_node r_node_q;
    logic [IdxW-1:0] r_free_q;

    logic            nm_we, nm_re, fm_we, fm_re;
    logic [IdxW-1:0] nm_waddr, nm_raddr, fm_waddr, fm_raddr, fm_wdata;
    blpm_pkg::t_node nm_wdata;

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            node_mem[nm_waddr] <= nm_wdata;
        end
        if (nm_re) begin
            r_node_q <= node_mem[nm_raddr];
        end
        if (fm_we) begin
            free_mem[fm_waddr] <= fm_wdata;
        end
        if (fm_re) begin
            r_free_q <= free_mem[fm_raddr];
        end
    end

    logic [3:0]                     r_state;
    logic [blpm_pkg::CmdW-1:0]      r_cmd;
    logic [blpm_pkg::AddrBits-1:0]  r_addr;
    logic [blpm_pkg::LenW-1:0]      r_len, r_depth;
    logic [blpm_pkg::LabelW-1:0]    r_label, r_best, r_dlabel;
    logic [blpm_pkg::StatW-1:0]     r_status;
    logic [IdxW-1:0]                r_n, r_c, r_root0, r_root1;
    blpm_pkg::t_node                r_nd;
    logic [CntW-1:0]                r_free_top, r_bump, r_count;

    logic            bit_s;
    logic [IdxW-1:0] child;
    logic            prune;
    logic [CntW:0]   avail;
    logic [blpm_pkg::LenW-1:0] need, len_in;
    blpm_pkg::t_node nd_link, nd_mark, q_clr, nd_new;

    always_comb begin
        bit_s = r_addr[blpm_pkg::AddrBits-1];
        if (r_n == '0) begin
            child = bit_s ? r_root1 : r_root0;
        end else begin
            child = bit_s ? r_nd.child1 : r_nd.child0;
        end
        prune = (r_n != '0) && !r_nd.marked && (r_nd.child0 == '0) && (r_nd.child1 == '0);
        need  = r_len - r_depth;
        avail = {1'b0, r_free_top} + ((CntW+1)'(blpm_pkg::NodeCount) - {1'b0, r_bump});
        len_in = (i_req.prefix_len > blpm_pkg::LenW'(blpm_pkg::AddrBits))
                 ? blpm_pkg::LenW'(blpm_pkg::AddrBits) : i_req.prefix_len;

        nd_link = r_nd;
        if (bit_s) begin
            nd_link.child1 = r_c;
        end else begin
            nd_link.child0 = r_c;
        end
        nd_mark        = r_nd;
        nd_mark.marked = 1'b1;
        nd_mark.label  = r_label;
        q_clr = r_node_q;
        if (r_node_q.child0 == r_n) begin
            q_clr.child0 = '0;
        end else begin
            q_clr.child1 = '0;
        end
        nd_new        = '0;
        nd_new.parent = r_n;

        nm_we    = 1'b0;
        nm_waddr = r_n;
        nm_wdata = r_nd;
        nm_re    = 1'b0;
        nm_raddr = child;
        fm_we    = 1'b0;
        fm_waddr = r_free_top[IdxW-1:0];
        fm_wdata = r_n;
        fm_re    = 1'b0;
        fm_raddr = IdxW'(r_free_top - CntW'(1));

        unique case (r_state)
            S_WALK: begin
                nm_re = (r_depth != r_len) && (child != '0);
            end
            S_A0: begin
                fm_re = (r_free_top != '0);
            end
            S_A2: begin
                nm_we    = (r_n != '0);
                nm_wdata = nd_link;
            end
            S_MARK: begin
                nm_we    = (r_n != '0);
                nm_wdata = nd_mark;
            end
            S_DCHK: begin
                nm_re    = prune;
                nm_raddr = r_nd.parent;
                fm_we    = prune && (r_free_top < CntMax);
                nm_we    = !prune && (r_n != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_root0    <= '0;
            r_root1    <= '0;
            r_free_top <= '0;
            r_bump     <= CntW'(1);
            r_count    <= '0;
            r_dlabel   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dlabel <= i_cfg_label;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cmd    <= i_req.command;
                        r_addr   <= i_req.address;
                        r_len    <= len_in;
                        r_label  <= i_req.label;
                        r_depth  <= '0;
                        r_n      <= '0;
                        r_best   <= r_dlabel;
                        r_status <= blpm_pkg::ST_OK;
                        priority if (i_req.command == blpm_pkg::CMD_INSERT ||
                                     i_req.command == blpm_pkg::CMD_LOOKUP) begin
                            r_state <= S_WALK;
                        end else if (i_req.command == blpm_pkg::CMD_DELETE && len_in != '0) begin
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WALK: begin
                    if (r_depth == r_len || child == '0) begin
                        unique case (r_cmd)
                            blpm_pkg::CMD_INSERT: r_state <= S_CAP;
                            blpm_pkg::CMD_DELETE: begin
                                if (r_depth != r_len || !r_nd.marked) begin
                                    r_status <= blpm_pkg::ST_ABSENT;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_nd.marked <= 1'b0;
                                    r_state     <= S_DCHK;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end else begin
                        r_n     <= child;
                        r_depth <= r_depth + LenOne;
                        r_addr  <= r_addr << 1;
                        r_state <= S_WLD;
                    end
                end
                S_WLD: begin
                    r_nd <= r_node_q;
                    if (r_node_q.marked) begin
                        r_best <= r_node_q.label;
                    end
                    r_state <= S_WALK;
                end
                S_CAP: begin
                    if ((CntW+1)'(need) > avail) begin
                        r_status <= blpm_pkg::ST_FULL;
                        r_state  <= S_DONE;
                    end else if (need == '0) begin
                        r_state <= S_MARK;
                    end else begin
                        r_state <= S_A0;
                    end
                end
                S_A0: begin
                    if (r_free_top != '0) begin
                        r_state <= S_A1;
                    end else begin
                        r_c     <= r_bump[IdxW-1:0];
                        r_bump  <= r_bump + CntW'(1);
                        r_state <= S_A2;
                    end
                end
                S_A1: begin
                    r_c        <= r_free_q;
                    r_free_top <= r_free_top - CntW'(1);
                    r_state    <= S_A2;
                end
                S_A2: begin
                    if (r_n == '0) begin
                        if (bit_s) begin
                            r_root1 <= r_c;
                        end else begin
                            r_root0 <= r_c;
                        end
                    end
                    r_nd    <= nd_new;
                    r_n     <= r_c;
                    r_depth <= r_depth + LenOne;
                    r_addr  <= r_addr << 1;
                    r_state <= (r_depth + LenOne == r_len) ? S_MARK : S_A0;
                end
                S_MARK: begin
                    if (r_n == '0) begin
                        r_dlabel <= r_label;
                    end
                    if (r_count < CntMax) begin
                        r_count <= r_count + CntW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DCHK: begin
                    if (prune) begin
                        if (r_free_top < CntMax) begin
                            r_free_top <= r_free_top + CntW'(1);
                        end
                        r_state <= S_DLD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DLD: begin
                    if (r_nd.parent == '0) begin
                        if (r_root0 == r_n) begin
                            r_root0 <= '0;
                        end else begin
                            r_root1 <= '0;
                        end
                    end else begin
                        r_nd <= q_clr;
                    end
                    r_n     <= r_nd.parent;
                    r_state <= S_DCHK;
                end
                S_DONE: begin
                    if (i_rsp_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp.result_label = (r_cmd == blpm_pkg::CMD_LOOKUP) ? r_best : '0;
    assign o_rsp.status       = r_status;
    assign o_rsp.entry_total  = r_count;

endmodule

// ===== hw/rtl/binary_trie_longest_prefix_match.sv =====
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// IPv4 style binary trie with insert, delete and longest prefix lookup.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Each trie level on the walk takes a node
// memory read (S_WALK) and a state to take the data (S_WLD); an insert passes
// through S_A0, S_A1 (free stack read, skipped if the stack is empty) and S_A2
// (link write) per newly allocated node, and a delete passes through S_DCHK and
// S_DLD per freed node on the way back up. The node memory has a registered read.
// Results go through an output register, so the next request starts while a
// result is still waiting. Node and free stack memories need no clearing after
// reset. Every request gives exactly one result. The user must write
// default_label through i_cfg_wr_en / i_cfg_wr_data only while the block is
// idle; the block itself does not enforce this.
module binary_trie_longest_prefix_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] address, [37:32] prefix_len, [53:38] label, [55:54] zero
    input  logic [55:0] i_s_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] result_label, [17:16] status, [30:18] entry_total, [31] zero
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    blpm_pkg::t_req req;
    blpm_pkg::t_rsp rsp;
    logic           rsp_valid, rsp_take;
    logic           r_m_valid;
    blpm_pkg::t_rsp r_m_rsp;

    assign req.command    = i_s_tuser;
    assign req.address    = i_s_tdata[31:0];
    assign req.prefix_len = i_s_tdata[37:32];
    assign req.label      = i_s_tdata[53:38];

    blpm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_take),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_label (i_cfg_wr_data)
    );

    // output slot frees when empty or being drained this cycle
    assign rsp_take = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (rsp_take) begin
            r_m_valid <= rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_take && rsp_valid) begin
            r_m_rsp <= rsp;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_rsp.entry_total, r_m_rsp.status, r_m_rsp.result_label};

endmodule
